// ----- design/cdtm_pkg.sv -----
// Shared types and constants for the color distance threshold mask block.
package cdtm_pkg;

   localparam int PIXEL_W  = 32;
   localparam int CHAN_W   = 8;
   localparam int SHIFT_W  = 5;
   localparam int LOSS_W   = 4;
   localparam int NUM_CHAN = 3;
   localparam int RGB_W    = NUM_CHAN * CHAN_W;
   localparam int SHIFTS_W = NUM_CHAN * SHIFT_W;
   localparam int LOSSES_W = NUM_CHAN * LOSS_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = RGB_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COMPARE_MODE  = 3'd0,
      CSR_REFERENCE_RGB = 3'd1,
      CSR_THRESHOLD_RGB = 3'd2,
      CSR_SHIFTS_A      = 3'd3,
      CSR_LOSSES_A      = 3'd4,
      CSR_SHIFTS_B      = 3'd5,
      CSR_LOSSES_B      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                compare_mode;
      logic [RGB_W-1:0]    reference_rgb;
      logic [RGB_W-1:0]    threshold_rgb;
      logic [SHIFTS_W-1:0] shifts_a;
      logic [LOSSES_W-1:0] losses_a;
      logic [SHIFTS_W-1:0] shifts_b;
      logic [LOSSES_W-1:0] losses_b;
   } cfg_type;

endpackage

// ----- design/cdtm_csr.sv -----
// Configuration register file for the color distance threshold mask block.
module cdtm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [cdtm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cdtm_pkg::CSR_DATA_W-1:0]  csr_data,
   output cdtm_pkg::cfg_type                cfg
);

   cdtm_pkg::cfg_type cfg_ff;
   cdtm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            cdtm_pkg::CSR_COMPARE_MODE:
               cfg_in.compare_mode = csr_data[0];
            cdtm_pkg::CSR_REFERENCE_RGB:
               cfg_in.reference_rgb = csr_data[cdtm_pkg::RGB_W-1:0];
            cdtm_pkg::CSR_THRESHOLD_RGB:
               cfg_in.threshold_rgb = csr_data[cdtm_pkg::RGB_W-1:0];
            cdtm_pkg::CSR_SHIFTS_A:
               cfg_in.shifts_a = csr_data[cdtm_pkg::SHIFTS_W-1:0];
            cdtm_pkg::CSR_LOSSES_A:
               cfg_in.losses_a = csr_data[cdtm_pkg::LOSSES_W-1:0];
            cdtm_pkg::CSR_SHIFTS_B:
               cfg_in.shifts_b = csr_data[cdtm_pkg::SHIFTS_W-1:0];
            cdtm_pkg::CSR_LOSSES_B:
               cfg_in.losses_b = csr_data[cdtm_pkg::LOSSES_W-1:0];
            default:
               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/cdtm_chan.sv -----
// One color channel: extract from both surfaces, take distance to surface B or the reference, compare to threshold.
module cdtm_chan (
   input  logic [cdtm_pkg::PIXEL_W-1:0] pixel_a,
   input  logic [cdtm_pkg::PIXEL_W-1:0] pixel_b,
   input  logic [cdtm_pkg::SHIFT_W-1:0] shift_a,
   input  logic [cdtm_pkg::LOSS_W-1:0]  loss_a,
   input  logic [cdtm_pkg::SHIFT_W-1:0] shift_b,
   input  logic [cdtm_pkg::LOSS_W-1:0]  loss_b,
   input  logic                         compare_mode,
   input  logic [cdtm_pkg::CHAN_W-1:0]  ref_chan,
   input  logic [cdtm_pkg::CHAN_W-1:0]  thr_chan,
   output logic                         below
);

   logic [cdtm_pkg::PIXEL_W-1:0] shifted_a;
   logic [cdtm_pkg::PIXEL_W-1:0] shifted_b;
   logic [cdtm_pkg::CHAN_W-1:0]  keep_a;
   logic [cdtm_pkg::CHAN_W-1:0]  keep_b;
   logic [cdtm_pkg::CHAN_W-1:0]  masked_a;
   logic [cdtm_pkg::CHAN_W-1:0]  masked_b;
   logic [cdtm_pkg::CHAN_W-1:0]  chan_a;
   logic [cdtm_pkg::CHAN_W-1:0]  chan_b;
   logic [cdtm_pkg::CHAN_W-1:0]  other;
   logic [cdtm_pkg::CHAN_W-1:0]  distance;

   always_comb begin
      shifted_a = pixel_a >> shift_a;
      shifted_b = pixel_b >> shift_b;
      keep_a    = {cdtm_pkg::CHAN_W{1'b1}} >> loss_a;
      keep_b    = {cdtm_pkg::CHAN_W{1'b1}} >> loss_b;
      masked_a  = shifted_a[cdtm_pkg::CHAN_W-1:0] & keep_a;
      masked_b  = shifted_b[cdtm_pkg::CHAN_W-1:0] & keep_b;
      chan_a    = masked_a << loss_a;
      chan_b    = masked_b << loss_b;
      other     = compare_mode ? chan_b : ref_chan;
      distance  = (chan_a > other) ? (chan_a - other) : (other - chan_a);
      below     = distance < thr_chan;
   end

endmodule

// ----- design/color_distance_threshold_mask.sv -----
// Top level: per-channel color threshold mask over a stream of pixel words.
// Pipeline: an input transfer loads the input register, which feeds three
// channel units; their result is registered, and rsp_valid rises with it.
// Throughput: one pixel per cycle while rsp_stall is low; the input and result
// registers each advance when the next stage frees up.
// Reset: synchronous; clears both pipeline valid bits and all config registers.
module color_distance_threshold_mask (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [cdtm_pkg::PIXEL_W-1:0]     req_pixel_a,
   input  logic [cdtm_pkg::PIXEL_W-1:0]     req_pixel_b,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_in_mask,
   input  logic                             csr_wr_en,
   input  logic [cdtm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cdtm_pkg::CSR_DATA_W-1:0]  csr_data
);

   cdtm_pkg::cfg_type cfg;

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [cdtm_pkg::PIXEL_W-1:0]  s1_pixel_a_ff;
   logic [cdtm_pkg::PIXEL_W-1:0]  s1_pixel_b_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          rsp_in_mask_ff;
   logic                          out_load;
   logic                          req_xfer;
   logic [cdtm_pkg::NUM_CHAN-1:0] below;

   cdtm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   for (genvar i = 0; i < cdtm_pkg::NUM_CHAN; i++) begin : g_chan
      cdtm_chan u_chan (
         .pixel_a      (s1_pixel_a_ff),
         .pixel_b      (s1_pixel_b_ff),
         .shift_a      (cfg.shifts_a[i*cdtm_pkg::SHIFT_W +: cdtm_pkg::SHIFT_W]),
         .loss_a       (cfg.losses_a[i*cdtm_pkg::LOSS_W +: cdtm_pkg::LOSS_W]),
         .shift_b      (cfg.shifts_b[i*cdtm_pkg::SHIFT_W +: cdtm_pkg::SHIFT_W]),
         .loss_b       (cfg.losses_b[i*cdtm_pkg::LOSS_W +: cdtm_pkg::LOSS_W]),
         .compare_mode (cfg.compare_mode),
         .ref_chan     (cfg.reference_rgb[i*cdtm_pkg::CHAN_W +: cdtm_pkg::CHAN_W]),
         .thr_chan     (cfg.threshold_rgb[i*cdtm_pkg::CHAN_W +: cdtm_pkg::CHAN_W]),
         .below        (below[i])
      );
   end

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_load;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (!s1_valid_ff || out_load) begin
         s1_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_pixel_a_ff <= req_pixel_a;
         s1_pixel_b_ff <= req_pixel_b;
      end
      if (out_load && s1_valid_ff) begin
         rsp_in_mask_ff <= &below;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_in_mask = rsp_in_mask_ff;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline valid bits not cleared by reset");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty input register");

   a_xfer_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> s1_valid_ff)
      else $error("transferred item lost from input register");

   a_s1_moves_out: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_load |=> rsp_valid_ff)
      else $error("item did not reach result register");

   a_zero_thr_clear: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_load && cfg.threshold_rgb == '0 && !csr_wr_en
      |=> !rsp_in_mask)
      else $error("mask set with zero thresholds");

endmodule

// ----- sim/color_distance_threshold_mask_tb.sv -----
// Testbench for the color distance threshold mask: directed and random pixels checked in order.
module color_distance_threshold_mask_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [cdtm_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int PHASE_ITEMS = 150;
   localparam int NUM_PHASES  = 9;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_stall;
   logic [cdtm_pkg::PIXEL_W-1:0]    req_pixel_a = '0;
   logic [cdtm_pkg::PIXEL_W-1:0]    req_pixel_b = '0;
   logic                            rsp_valid;
   logic                            rsp_stall   = 1'b0;
   logic                            rsp_in_mask;
   logic                            csr_wr_en   = 1'b0;
   logic [cdtm_pkg::CSR_IDX_W-1:0]  csr_index   = '0;
   logic [cdtm_pkg::CSR_DATA_W-1:0] csr_data    = '0;

   cdtm_pkg::cfg_type cfg_shadow = '0;
   logic              mask_expected_q[$];
   logic              expected_mask;
   logic              no_idle    = 1'b0;
   int                fail_count = 0;

   color_distance_threshold_mask u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_pixel_a (req_pixel_a),
      .req_pixel_b (req_pixel_b),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_in_mask (rsp_in_mask),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < 37);
   end

   function automatic logic [cdtm_pkg::CHAN_W-1:0] channel_level(
      input logic [cdtm_pkg::PIXEL_W-1:0]  pix,
      input logic [cdtm_pkg::SHIFTS_W-1:0] shifts,
      input logic [cdtm_pkg::LOSSES_W-1:0] losses,
      input int                            ch);
      logic [31:0] sh;
      logic [31:0] ls;
      logic [31:0] keep;
      logic [31:0] level;
      sh    = 32'(shifts[cdtm_pkg::SHIFT_W*ch +: cdtm_pkg::SHIFT_W]);
      ls    = 32'(losses[cdtm_pkg::LOSS_W*ch +: cdtm_pkg::LOSS_W]);
      keep  = 32'd255 >> ls;
      level = ((pix >> sh) & keep) << ls;
      return level[cdtm_pkg::CHAN_W-1:0];
   endfunction

   function automatic logic predict_in_mask(input logic [cdtm_pkg::PIXEL_W-1:0] pa,
                                            input logic [cdtm_pkg::PIXEL_W-1:0] pb);
      logic [cdtm_pkg::CHAN_W-1:0] ca;
      logic [cdtm_pkg::CHAN_W-1:0] other;
      logic [cdtm_pkg::CHAN_W-1:0] thr;
      logic [cdtm_pkg::CHAN_W-1:0] diff;
      logic                        all_in;
      all_in = 1'b1;
      for (int ch = 0; ch < cdtm_pkg::NUM_CHAN; ch++) begin
         ca  = channel_level(pa, cfg_shadow.shifts_a, cfg_shadow.losses_a, ch);
         thr = cfg_shadow.threshold_rgb[cdtm_pkg::CHAN_W*ch +: cdtm_pkg::CHAN_W];
         if (cfg_shadow.compare_mode) begin
            other = channel_level(pb, cfg_shadow.shifts_b, cfg_shadow.losses_b, ch);
         end else begin
            other = cfg_shadow.reference_rgb[cdtm_pkg::CHAN_W*ch +: cdtm_pkg::CHAN_W];
         end
         diff = (ca > other) ? ca - other : other - ca;
         if (!(diff < thr)) all_in = 1'b0;
      end
      return all_in;
   endfunction

   // Overwrite each channel field of pix so that it reads close to target.
   function automatic logic [cdtm_pkg::PIXEL_W-1:0] place_near(
      input logic [cdtm_pkg::PIXEL_W-1:0]  pix,
      input logic [cdtm_pkg::SHIFTS_W-1:0] shifts,
      input logic [cdtm_pkg::LOSSES_W-1:0] losses,
      input logic [cdtm_pkg::RGB_W-1:0]    target);
      logic [31:0] sh;
      logic [31:0] ls;
      logic [31:0] keep;
      int          level;
      sh = '0;
      for (int ch = 0; ch < cdtm_pkg::NUM_CHAN; ch++) begin
         sh    = 32'(shifts[cdtm_pkg::SHIFT_W*ch +: cdtm_pkg::SHIFT_W]);
         ls    = 32'(losses[cdtm_pkg::LOSS_W*ch +: cdtm_pkg::LOSS_W]);
         keep  = 32'd255 >> ls;
         level = int'(target[cdtm_pkg::CHAN_W*ch +: cdtm_pkg::CHAN_W])
                 + $urandom_range(0, 16) - 8;
         if (level < 0) level = 0;
         if (level > 255) level = 255;
         pix = (pix & ~(keep << sh)) | (((32'(level) >> ls) & keep) << sh);
      end
      return pix;
   endfunction

   function automatic cdtm_pkg::cfg_type random_config();
      cdtm_pkg::cfg_type c;
      c.compare_mode  = 1'($urandom_range(0, 1));
      c.reference_rgb = 24'($urandom);
      case ($urandom_range(0, 9))
         0:       c.threshold_rgb = 24'($urandom);
         1:       c.threshold_rgb = 24'hFFFFFF;
         default: c.threshold_rgb = {8'($urandom_range(1, 64)), 8'($urandom_range(1, 64)),
                                     8'($urandom_range(1, 64))};
      endcase
      for (int s = 0; s < 2; s++) begin
         logic [cdtm_pkg::SHIFTS_W-1:0] shifts;
         logic [cdtm_pkg::LOSSES_W-1:0] losses;
         case ($urandom_range(0, 5))
            0: begin shifts = {5'd16, 5'd8, 5'd0};  losses = 12'h000; end
            1: begin shifts = {5'd0, 5'd8, 5'd16};  losses = 12'h000; end
            2: begin shifts = {5'd11, 5'd5, 5'd0};  losses = 12'h323; end
            3: begin shifts = {5'd10, 5'd5, 5'd0};  losses = 12'h333; end
            4: begin
               shifts = 15'($urandom);
               losses = {4'($urandom_range(0, 8)), 4'($urandom_range(0, 8)),
                         4'($urandom_range(0, 8))};
            end
            default: begin shifts = 15'($urandom); losses = 12'($urandom); end
         endcase
         if (s == 0) begin
            c.shifts_a = shifts;
            c.losses_a = losses;
         end else begin
            c.shifts_b = shifts;
            c.losses_b = losses;
         end
      end
      return c;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mask_expected_q.size() == 0) begin
            $error("in_mask: no transfer expected, actual %0b", rsp_in_mask);
            fail_count++;
         end else begin
            expected_mask = mask_expected_q.pop_front();
            if (rsp_in_mask !== expected_mask) begin
               $error("in_mask: expected %0b, actual %0b", expected_mask, rsp_in_mask);
               fail_count++;
            end
         end
      end
   end

   task automatic send_pixel(input logic [cdtm_pkg::PIXEL_W-1:0] pa,
                             input logic [cdtm_pkg::PIXEL_W-1:0] pb);
      while (!no_idle && $urandom_range(0, 99) < 37) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_pixel_a <= pa;
      req_pixel_b <= pb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mask_expected_q.push_back(predict_in_mask(pa, pb));
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (mask_expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // Leaves the write enable high; the caller drops it after the last write.
   task automatic write_csr(input logic [cdtm_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [cdtm_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      case (idx)
         cdtm_pkg::CSR_COMPARE_MODE:
            cfg_shadow.compare_mode  = data[0];
         cdtm_pkg::CSR_REFERENCE_RGB:
            cfg_shadow.reference_rgb = data[cdtm_pkg::RGB_W-1:0];
         cdtm_pkg::CSR_THRESHOLD_RGB:
            cfg_shadow.threshold_rgb = data[cdtm_pkg::RGB_W-1:0];
         cdtm_pkg::CSR_SHIFTS_A:
            cfg_shadow.shifts_a      = data[cdtm_pkg::SHIFTS_W-1:0];
         cdtm_pkg::CSR_LOSSES_A:
            cfg_shadow.losses_a      = data[cdtm_pkg::LOSSES_W-1:0];
         cdtm_pkg::CSR_SHIFTS_B:
            cfg_shadow.shifts_b      = data[cdtm_pkg::SHIFTS_W-1:0];
         cdtm_pkg::CSR_LOSSES_B:
            cfg_shadow.losses_b      = data[cdtm_pkg::LOSSES_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic load_config(input cdtm_pkg::cfg_type c);
      write_csr(cdtm_pkg::CSR_COMPARE_MODE,  cdtm_pkg::CSR_DATA_W'(c.compare_mode));
      write_csr(cdtm_pkg::CSR_REFERENCE_RGB, cdtm_pkg::CSR_DATA_W'(c.reference_rgb));
      write_csr(cdtm_pkg::CSR_THRESHOLD_RGB, cdtm_pkg::CSR_DATA_W'(c.threshold_rgb));
      write_csr(cdtm_pkg::CSR_SHIFTS_A,      cdtm_pkg::CSR_DATA_W'(c.shifts_a));
      write_csr(cdtm_pkg::CSR_LOSSES_A,      cdtm_pkg::CSR_DATA_W'(c.losses_a));
      write_csr(cdtm_pkg::CSR_SHIFTS_B,      cdtm_pkg::CSR_DATA_W'(c.shifts_b));
      write_csr(cdtm_pkg::CSR_LOSSES_B,      cdtm_pkg::CSR_DATA_W'(c.losses_b));
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_reset_state();
      send_pixel(32'h0000_0000, 32'h0000_0000);
      send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_drain();
   endtask

   task automatic test_reference_match();
      load_config('{compare_mode: 1'b0, reference_rgb: 24'h8040C0, threshold_rgb: 24'h101010,
                    shifts_a: {5'd16, 5'd8, 5'd0}, losses_a: 12'h000,
                    shifts_b: 15'h0000, losses_b: 12'h000});
      send_pixel(32'h0080_40C0, 32'hFFFF_FFFF);
      send_pixel(32'hAB8F_40C0, 32'h0000_0000);
      send_pixel(32'h0090_40C0, 32'h0000_0000);
      send_pixel(32'h0080_31C0, 32'h0000_0000);
      send_pixel(32'h0080_40B0, 32'h0000_0000);
      wait_drain();
      load_config('{compare_mode: 1'b0, reference_rgb: 24'h000000, threshold_rgb: 24'hFFFFFF,
                    shifts_a: {5'd16, 5'd8, 5'd0}, losses_a: 12'h000,
                    shifts_b: 15'h0000, losses_b: 12'h000});
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(32'h00FE_FEFE, 32'h0000_0000);
      wait_drain();
   endtask

   task automatic test_surface_compare();
      load_config('{compare_mode: 1'b1, reference_rgb: 24'hFFFFFF, threshold_rgb: 24'h010101,
                    shifts_a: {5'd16, 5'd8, 5'd0}, losses_a: 12'h000,
                    shifts_b: {5'd0, 5'd8, 5'd16}, losses_b: 12'h000});
      send_pixel(32'h0011_2233, 32'h0033_2211);
      send_pixel(32'h0011_2233, 32'h0033_2212);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
      wait_drain();
      load_config('{compare_mode: 1'b1, reference_rgb: 24'h000000, threshold_rgb: 24'h818181,
                    shifts_a: 15'h7FFF, losses_a: 12'h777,
                    shifts_b: {5'd11, 5'd5, 5'd0}, losses_b: 12'h323});
      send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(32'h8000_0000, 32'h0000_0000);
      wait_drain();
   endtask

   task automatic test_deep_loss();
      load_config('{compare_mode: 1'b0, reference_rgb: 24'h000000, threshold_rgb: 24'h010101,
                    shifts_a: {5'd16, 5'd8, 5'd0}, losses_a: 12'h9F8,
                    shifts_b: 15'h0000, losses_b: 12'hFFF});
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
      wait_drain();
      write_csr(cdtm_pkg::CSR_REFERENCE_RGB, 24'h010000);
      csr_wr_en <= 1'b0;
      send_pixel(32'h00FF_FFFF, 32'h0000_0000);
      wait_drain();
   endtask

   task automatic test_register_writes();
      write_csr(CSR_UNUSED,                  24'hFFFFFF);
      write_csr(cdtm_pkg::CSR_COMPARE_MODE,  24'hFFFFFE);
      write_csr(cdtm_pkg::CSR_SHIFTS_A,      24'hFF8000 | 24'(15'b10000_01000_00000));
      write_csr(cdtm_pkg::CSR_LOSSES_A,      24'hFFF000);
      write_csr(cdtm_pkg::CSR_THRESHOLD_RGB, 24'h080808);
      write_csr(cdtm_pkg::CSR_REFERENCE_RGB, 24'h123456);
      csr_wr_en <= 1'b0;
      send_pixel(32'hFF12_3456, 32'hFFFF_FFFF);
      send_pixel(32'h0012_3460, 32'h0000_0000);
      wait_drain();
   endtask

   task automatic test_random_stream();
      cdtm_pkg::cfg_type              c;
      logic [cdtm_pkg::PIXEL_W-1:0]   pa;
      logic [cdtm_pkg::PIXEL_W-1:0]   pb;
      logic [cdtm_pkg::RGB_W-1:0]     level_a;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         c = random_config();
         if (phase == 0) begin
            c = '1;
         end else if (phase == NUM_PHASES - 1) begin
            c = '0;
         end
         load_config(c);
         no_idle = (phase == 5);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 4 && n == PHASE_ITEMS / 2) wait_drain();
            pa = $urandom;
            pb = $urandom;
            if ($urandom_range(0, 99) < 70) begin
               if (cfg_shadow.compare_mode) begin
                  for (int ch = 0; ch < cdtm_pkg::NUM_CHAN; ch++) begin
                     level_a[cdtm_pkg::CHAN_W*ch +: cdtm_pkg::CHAN_W] =
                        channel_level(pa, cfg_shadow.shifts_a, cfg_shadow.losses_a, ch);
                  end
                  pb = place_near(pb, cfg_shadow.shifts_b, cfg_shadow.losses_b, level_a);
               end else begin
                  pa = place_near(pa, cfg_shadow.shifts_a, cfg_shadow.losses_a,
                                  cfg_shadow.reference_rgb);
               end
            end
            send_pixel(pa, pb);
         end
         wait_drain();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_state();
      test_reference_match();
      test_surface_compare();
      test_deep_loss();
      test_register_writes();
      test_random_stream();
      wait_drain();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- color_distance_threshold_mask.f -----
design/cdtm_pkg.sv
design/cdtm_csr.sv
design/cdtm_chan.sv
design/color_distance_threshold_mask.sv
sim/color_distance_threshold_mask_tb.sv
